// ----- hdl/lha_pkg.sv -----
// Shared constants, codes and control types for the latency histogram block.
`default_nettype none

package lha_pkg;

  // Histogram geometry
  localparam int NUM_LEVELS     = 7;
  localparam int MAX_ORDER_SLOT = 10;
  localparam int NUM_SLOTS      = 13;
  localparam int TABLE_DEPTH    = NUM_LEVELS * NUM_SLOTS;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int LVL_W          = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // Field widths
  localparam int ACTION_W     = 3;
  localparam int STAMP_W      = 64;
  localparam int ORDER_W      = 5;
  localparam int READ_LEVEL_W = 3;
  localparam int READ_SLOT_W  = 4;
  localparam int SLOT_W       = READ_SLOT_W;
  localparam int DATA_W       = 64;
  localparam int THRESH_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_BASE = 3'd1;

  // Threshold values after reset, in ns
  localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_LEVELS] = '{
    32'd1000000, 32'd5000000, 32'd10000000, 32'd50000000,
    32'd100000000, 32'd500000000, 32'd1000000000
  };

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC_START = 3'd0,
    ACT_ALLOC_END   = 3'd1,
    ACT_FAULT_START = 3'd2,
    ACT_FAULT_END   = 3'd3,
    ACT_SPEC_START  = 3'd4,
    ACT_SPEC_END    = 3'd5,
    ACT_READ        = 3'd6
  } lha_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_UPDATE,
    S_RESPOND
  } lha_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic decode;
    logic fetch;
    logic update;
    logic load_out;
  } lha_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic record;
    logic out_free;
  } lha_sts_t;

endpackage

`default_nettype wire

// ----- hdl/lha_channels.sv -----
// Valid/ready channel interfaces for event transactions and read results.
`default_nettype none

interface lha_in_if import lha_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACTION_W-1:0]     action;
  logic [STAMP_W-1:0]      now_ns;
  logic [ORDER_W-1:0]      alloc_order;
  logic                    read_kind;
  logic [READ_LEVEL_W-1:0] read_level;
  logic [READ_SLOT_W-1:0]  read_slot;

  modport source (
    output valid, action, now_ns, alloc_order, read_kind, read_level, read_slot,
    input  ready
  );
  modport sink (
    input  valid, action, now_ns, alloc_order, read_kind, read_level, read_slot,
    output ready
  );
endinterface

interface lha_out_if import lha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/lha_ctrl.sv -----
// Sequencing state machine for the latency histogram block.
`default_nettype none

module lha_ctrl import lha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lha_sts_t sts,
  output lha_cmd_t cmd
);

  lha_state_t st_r;
  lha_state_t st_nxt;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid) st_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.is_read || sts.record) st_nxt = S_FETCH;
        else st_nxt = S_IDLE;
      end
      S_FETCH: begin
        st_nxt = sts.is_read ? S_RESPOND : S_UPDATE;
      end
      S_UPDATE: begin
        st_nxt = S_IDLE;
      end
      S_RESPOND: begin
        if (sts.out_free) st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_DECODE:  cmd.decode   = 1'b1;
      S_FETCH:   cmd.fetch    = 1'b1;
      S_UPDATE:  cmd.update   = 1'b1;
      S_RESPOND: cmd.load_out = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_update_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_UPDATE) |-> ($past(st_r) == S_FETCH))
    else $error("table update without a preceding fetch");

  a_respond_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RESPOND) |-> ($past(st_r) == S_FETCH || $past(st_r) == S_RESPOND))
    else $error("response without a preceding fetch");
`endif

endmodule

`default_nettype wire

// ----- hdl/lha_datapath.sv -----
// Timestamps, binning logic, histogram tables and result register.
`default_nettype none

module lha_datapath import lha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lha_in_if.sink                in_ch,
  lha_out_if.source             out_ch,
  input  lha_cmd_t              cmd,
  output lha_sts_t              sts
);

  // Configuration
  logic                enable_r;
  logic [THRESH_W-1:0] thresh_r [NUM_LEVELS];

  // Held transaction
  logic [ACTION_W-1:0]     act_r;
  logic [STAMP_W-1:0]      now_r;
  logic [ORDER_W-1:0]      order_r;
  logic                    kind_r;
  logic [READ_LEVEL_W-1:0] level_r;
  logic [READ_SLOT_W-1:0]  slot_r;

  // Start stamps
  logic [STAMP_W-1:0] alloc_stamp_r, alloc_stamp_nxt;
  logic [STAMP_W-1:0] fault_stamp_r, fault_stamp_nxt;

  // Decode results
  logic [STAMP_W-1:0]    stamp_sel;
  logic [STAMP_W-1:0]    delay;
  logic                  backward;
  logic                  stamp_open;
  logic [NUM_LEVELS-1:0] below;
  logic                  found;
  logic [LVL_W-1:0]      lvl;
  logic [SLOT_W-1:0]     end_slot;
  logic                  is_end;
  logic                  is_read;
  logic                  rec_nxt;
  logic                  rd_ok;
  logic [ADDR_W-1:0]     end_addr;
  logic [ADDR_W-1:0]     rd_addr;

  logic [ADDR_W-1:0]  addr_r;
  logic [STAMP_W-1:0] delay_r;
  logic               use_r;

  // Tables
  logic [DATA_W-1:0]      sum_mem [TABLE_DEPTH];
  logic [DATA_W-1:0]      cnt_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [DATA_W-1:0]      sum_rd_r;
  logic [DATA_W-1:0]      cnt_rd_r;
  logic                   hit_rd_r;
  logic [DATA_W-1:0]      sum_base;
  logic [DATA_W-1:0]      cnt_base;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) thresh_r[i] <= THRESH_RESET[i];
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENABLE) enable_r <= cfg_wdata[0];
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (cfg_index == CFG_THRESH_BASE + CFG_IDX_W'(i)) thresh_r[i] <= cfg_wdata;
      end
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_r   <= in_ch.action;
      now_r   <= in_ch.now_ns;
      order_r <= in_ch.alloc_order;
      kind_r  <= in_ch.read_kind;
      level_r <= in_ch.read_level;
      slot_r  <= in_ch.read_slot;
    end
  end

  // Delay and level search
  always_comb begin
    is_end     = act_r inside {ACT_ALLOC_END, ACT_FAULT_END, ACT_SPEC_END};
    is_read    = (act_r == ACT_READ);
    stamp_sel  = (act_r == ACT_ALLOC_END) ? alloc_stamp_r : fault_stamp_r;
    delay      = now_r - stamp_sel;
    backward   = now_r < stamp_sel;
    stamp_open = (stamp_sel != '0);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      below[i] = (delay[STAMP_W-1:THRESH_W] == '0) && (delay[THRESH_W-1:0] < thresh_r[i]);
    end
    found = |below;
    lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (below[i]) lvl = LVL_W'(i);
    end
    case (act_r)
      ACT_ALLOC_END: begin
        end_slot = (order_r > ORDER_W'(MAX_ORDER_SLOT)) ? SLOT_W'(MAX_ORDER_SLOT)
                                                        : SLOT_W'(order_r);
      end
      ACT_SPEC_END: end_slot = SLOT_W'(MAX_ORDER_SLOT + 2);
      default:      end_slot = SLOT_W'(MAX_ORDER_SLOT + 1);
    endcase
    end_addr = ADDR_W'(lvl) * ADDR_W'(NUM_SLOTS) + ADDR_W'(end_slot);
    rec_nxt  = enable_r && is_end && stamp_open && !backward && found
               && (end_slot < NUM_SLOTS);
    rd_ok    = enable_r && (level_r < NUM_LEVELS) && (slot_r < NUM_SLOTS);
    rd_addr  = rd_ok ? ADDR_W'(level_r) * ADDR_W'(NUM_SLOTS) + ADDR_W'(slot_r) : '0;
  end

  // Latch or clear start stamps
  always_comb begin
    alloc_stamp_nxt = alloc_stamp_r;
    fault_stamp_nxt = fault_stamp_r;
    if (cmd.decode && enable_r) begin
      case (act_r)
        ACT_ALLOC_START:                alloc_stamp_nxt = now_r;
        ACT_ALLOC_END:                  alloc_stamp_nxt = '0;
        ACT_FAULT_START, ACT_SPEC_START: fault_stamp_nxt = now_r;
        ACT_FAULT_END, ACT_SPEC_END:    fault_stamp_nxt = '0;
        default: begin
          alloc_stamp_nxt = alloc_stamp_r;
          fault_stamp_nxt = fault_stamp_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_stamp_r <= '0;
      fault_stamp_r <= '0;
    end else begin
      alloc_stamp_r <= alloc_stamp_nxt;
      fault_stamp_r <= fault_stamp_nxt;
    end
  end

  // Hold table address and delay for the fetch and update steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= 1'b0;
    end else if (cmd.decode) begin
      use_r <= is_read ? rd_ok : rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      addr_r  <= is_read ? rd_addr : end_addr;
      delay_r <= delay;
    end
  end

  // Table read and read-modify-write
  assign sum_base = hit_rd_r ? sum_rd_r : '0;
  assign cnt_base = hit_rd_r ? cnt_rd_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      sum_rd_r <= sum_mem[addr_r];
      cnt_rd_r <= cnt_mem[addr_r];
    end
    if (cmd.update) begin
      sum_mem[addr_r] <= sum_base + delay_r;
      cnt_mem[addr_r] <= cnt_base + DATA_W'(1);
    end
  end

  // Entry valid bits: an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      hit_rd_r <= 1'b0;
    end else begin
      if (cmd.fetch) hit_rd_r <= valid_r[addr_r];
      if (cmd.update) valid_r[addr_r] <= 1'b1;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (use_r && hit_rd_r) ? (kind_r ? cnt_rd_r : sum_rd_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

  // Status
  assign sts.is_read  = is_read;
  assign sts.record   = rec_nxt;
  assign sts.out_free = !out_valid_r || out_ch.ready;

`ifndef SYNTHESIS
  a_update_marks_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> valid_r[$past(addr_r)])
    else $error("updated table entry not marked valid");

  a_disabled_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && !enable_r) |=> (out_valid_r && out_data_r == '0))
    else $error("read while disabled returned nonzero data");

  a_alloc_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.decode && rec_nxt && act_r == ACT_ALLOC_END) |=> (alloc_stamp_r == '0))
    else $error("allocation start stamp not cleared after recording");
`endif

endmodule

`default_nettype wire

// ----- hdl/latency_histogram_accumulator.sv -----
// Top level of the event latency histogram accumulator.
//
//  channel  | dir | transfer                 | payload
//  ---------+-----+--------------------------+------------------------------------------
//  in_ch    | in  | valid && ready           | action, now_ns, alloc_order, read_kind,
//           |     |                          | read_level, read_slot
//  out_ch   | out | valid && ready           | read_data (one per read transaction)
//  cfg_*    | in  | cfg_we high at clock edge| cfg_index selects register, cfg_wdata
//
//  One transaction is processed at a time. Start events and events that record
//  nothing pass through decode only; a recording end event goes through decode,
//  table fetch and table write (the single-port table read-modify-write); a read
//  takes decode, table fetch and respond, which waits while the result register is full.
//  Synchronous active-low reset clears stamps, control and the per-entry valid
//  bits, so the tables read as zero at once; no clearing pass is needed.
//  A new transaction is accepted while a finished result waits in out_ch.
`default_nettype none

module latency_histogram_accumulator import lha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lha_in_if.sink                in_ch,
  lha_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lha_cmd_t cmd;
  lha_sts_t sts;
  logic     in_ready;

  lha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lha_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the latency histogram accumulator.
`timescale 1ns / 1ps

module tb_top;
  import lha_pkg::*;

  // Action code the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_NONE = 3'd7;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [ACTION_W-1:0]     action;
    logic [STAMP_W-1:0]      now_ns;
    logic [ORDER_W-1:0]      order;
    logic                    kind;
    logic [READ_LEVEL_W-1:0] level;
    logic [READ_SLOT_W-1:0]  slot;
  } event_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lha_in_if  in_ch ();
  lha_out_if out_ch ();

  latency_histogram_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted histogram state and settings
  logic                hist_on;
  logic [THRESH_W-1:0] level_bound [NUM_LEVELS];
  logic [THRESH_W-1:0] next_bound [NUM_LEVELS];
  logic [STAMP_W-1:0]  alloc_open_ns;
  logic [STAMP_W-1:0]  fault_open_ns;
  logic [DATA_W-1:0]   delay_sum [TABLE_DEPTH];
  logic [DATA_W-1:0]   event_count [TABLE_DEPTH];

  event_t            event_queue[$];
  logic [DATA_W-1:0] expected_reads[$];

  event_t            drive_ev;
  event_t            seen_ev;
  logic [DATA_W-1:0] want_data;
  logic              in_taken;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                events_pushed;
  int                events_taken;
  int                reads_checked;
  int                fail_count;
  int                quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bin one delay into the first level whose bound exceeds it
  task automatic bin_delay(input logic [STAMP_W-1:0] start_ns, input logic [STAMP_W-1:0] end_ns,
                           input int slot);
    logic [STAMP_W-1:0] delay;
    bit                 placed;
    int                 idx;
    placed = 1'b0;
    delay = end_ns - start_ns;
    if (end_ns >= start_ns && slot < NUM_SLOTS) begin
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
        if (!placed && delay < level_bound[lv]) begin
          idx = lv * NUM_SLOTS + slot;
          delay_sum[idx] += delay;
          event_count[idx] += 64'd1;
          placed = 1'b1;
        end
      end
    end
  endtask

  // Advance the predicted state by one accepted transaction
  task automatic model_event(input event_t ev);
    logic [DATA_W-1:0] rd;
    int                order_slot;
    case (ev.action)
      ACT_ALLOC_START: if (hist_on) alloc_open_ns = ev.now_ns;
      ACT_ALLOC_END: begin
        if (hist_on && alloc_open_ns != '0) begin
          order_slot = (ev.order > MAX_ORDER_SLOT) ? MAX_ORDER_SLOT : int'(ev.order);
          bin_delay(alloc_open_ns, ev.now_ns, order_slot);
          alloc_open_ns = '0;
        end
      end
      ACT_FAULT_START, ACT_SPEC_START: if (hist_on) fault_open_ns = ev.now_ns;
      ACT_FAULT_END, ACT_SPEC_END: begin
        if (hist_on && fault_open_ns != '0) begin
          bin_delay(fault_open_ns, ev.now_ns,
                    (ev.action == ACT_SPEC_END) ? MAX_ORDER_SLOT + 2 : MAX_ORDER_SLOT + 1);
          fault_open_ns = '0;
        end
      end
      ACT_READ: begin
        rd = '0;
        if (hist_on && ev.level < NUM_LEVELS && ev.slot < NUM_SLOTS)
          rd = ev.kind ? event_count[ev.level * NUM_SLOTS + ev.slot]
                       : delay_sum[ev.level * NUM_SLOTS + ev.slot];
        expected_reads.push_back(rd);
      end
      default: ;
    endcase
  endtask

  // Drive inputs on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_ev = event_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.action      <= drive_ev.action;
          in_ch.now_ns      <= drive_ev.now_ns;
          in_ch.alloc_order <= drive_ev.order;
          in_ch.read_kind   <= drive_ev.kind;
          in_ch.read_level  <= drive_ev.level;
          in_ch.read_slot   <= drive_ev.slot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample both channels on the rising edge, predict and check
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        seen_ev.action = in_ch.action;
        seen_ev.now_ns = in_ch.now_ns;
        seen_ev.order  = in_ch.alloc_order;
        seen_ev.kind   = in_ch.read_kind;
        seen_ev.level  = in_ch.read_level;
        seen_ev.slot   = in_ch.read_slot;
        model_event(seen_ev);
        events_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: read result with none expected: expected nothing, got %h",
                   $time, out_ch.read_data);
          fail_count++;
        end else begin
          want_data = expected_reads.pop_front();
          reads_checked++;
          if (out_ch.read_data !== want_data) begin
            $display("%0t: read_data mismatch: expected %h, got %h",
                     $time, want_data, out_ch.read_data);
            fail_count++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic event_t noise_event();
    event_t ev;
    ev.action = ACTION_W'($urandom_range(7));
    ev.now_ns = rand64();
    ev.order  = ORDER_W'($urandom_range(31));
    ev.kind   = 1'($urandom_range(1));
    ev.level  = READ_LEVEL_W'($urandom_range(7));
    ev.slot   = READ_SLOT_W'($urandom_range(15));
    return ev;
  endfunction

  task automatic queue_event(input event_t ev);
    event_queue.push_back(ev);
    events_pushed++;
  endtask

  // Timed event; fields it does not use stay random
  task automatic push_event(input logic [ACTION_W-1:0] act, input logic [STAMP_W-1:0] now_ns,
                            input logic [ORDER_W-1:0] order);
    event_t ev;
    ev = noise_event();
    ev.action = act;
    ev.now_ns = now_ns;
    ev.order  = order;
    queue_event(ev);
  endtask

  task automatic push_read(input logic kind, input logic [READ_LEVEL_W-1:0] level,
                           input logic [READ_SLOT_W-1:0] slot);
    event_t ev;
    ev = noise_event();
    ev.action = ACT_READ;
    ev.kind   = kind;
    ev.level  = level;
    ev.slot   = slot;
    queue_event(ev);
  endtask

  // Start stamps: zero, near wrap, small or full range
  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return ~64'd0 - $urandom_range(2000);
      2, 3:    return {32'd0, $urandom};
      default: return rand64();
    endcase
  endfunction

  // Delays aimed at the current level bounds, with backward and oversize ones
  function automatic logic [63:0] rand_delay();
    int          lv;
    logic [31:0] lo;
    lv = $urandom_range(NUM_LEVELS - 1);
    case ($urandom_range(11))
      0: return 64'd0 - 64'($urandom_range(5000, 1));
      1: return rand64();
      2: return {32'd0, level_bound[lv]};
      3: return {32'd0, level_bound[lv]} - 64'd1;
      4: return {32'd0, $urandom};
      default: begin
        lo = 32'd0;
        if (lv > 0 && level_bound[lv-1] < level_bound[lv])
          lo = level_bound[lv-1];
        if (level_bound[lv] == 32'd0)
          return 64'd0;
        return {32'd0, 32'($urandom_range(level_bound[lv] - 1, lo))};
      end
    endcase
  endfunction

  // Mostly complete start/end pairs and reads, some noise
  task automatic gen_traffic(input int count);
    logic [63:0]         a0;
    logic [63:0]         f0;
    logic [ACTION_W-1:0] f_start;
    logic [ACTION_W-1:0] f_end;
    int                  made;
    int                  pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      a0 = rand_stamp();
      f0 = rand_stamp();
      f_start = $urandom_range(1) ? ACT_SPEC_START : ACT_FAULT_START;
      f_end = $urandom_range(1) ? ACT_SPEC_END : ACT_FAULT_END;
      if (pick < 30) begin
        push_event(ACT_ALLOC_START, a0, ORDER_W'($urandom_range(31)));
        push_event(ACT_ALLOC_END, a0 + rand_delay(), ORDER_W'($urandom_range(31)));
        made += 2;
      end else if (pick < 50) begin
        push_event(f_start, f0, ORDER_W'($urandom_range(31)));
        push_event(f_end, f0 + rand_delay(), ORDER_W'($urandom_range(31)));
        made += 2;
      end else if (pick < 58) begin
        push_event(ACT_ALLOC_START, a0, ORDER_W'($urandom_range(31)));
        push_event(f_start, f0, ORDER_W'($urandom_range(31)));
        push_event(ACT_ALLOC_END, a0 + rand_delay(), ORDER_W'($urandom_range(31)));
        push_event(f_end, f0 + rand_delay(), ORDER_W'($urandom_range(31)));
        made += 4;
      end else if (pick < 88) begin
        push_read(1'($urandom_range(1)),
                  READ_LEVEL_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                         : $urandom_range(NUM_LEVELS - 1)),
                  READ_SLOT_W'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                        : $urandom_range(NUM_SLOTS - 1)));
        made++;
      end else begin
        queue_event(noise_event());
        made++;
      end
    end
  endtask

  // Hold until every transaction is taken and every read has returned
  task automatic drain();
    do
      @(negedge clk);
    while (events_taken != events_pushed || expected_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Call on a falling edge while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_ENABLE)
      hist_on = val[0];
    else
      level_bound[idx - CFG_THRESH_BASE] = val;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] enable_word);
    write_reg(CFG_ENABLE, enable_word);
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      write_reg(CFG_IDX_W'(CFG_THRESH_BASE + lv), next_bound[lv]);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] enable_word, input int send_pct,
                           input int recv_pct, input int count);
    configure(enable_word);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    gen_traffic(count);
    drain();
  endtask

  initial begin
    int acc;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = '0;
    in_ch.now_ns      = '0;
    in_ch.alloc_order = '0;
    in_ch.read_kind   = 1'b0;
    in_ch.read_level  = '0;
    in_ch.read_slot   = '0;
    out_ch.ready      = 1'b0;
    in_taken          = 1'b0;
    hist_on           = 1'b0;
    alloc_open_ns     = '0;
    fault_open_ns     = '0;
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      level_bound[lv] = THRESH_RESET[lv];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      delay_sum[i] = '0;
      event_count[i] = '0;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    events_pushed  = 0;
    events_taken   = 0;
    reads_checked  = 0;
    fail_count     = 0;
    quiet_cycles   = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Accounting off after reset: events do nothing, reads return zero
    @(posedge clk);
    push_read(1'b1, 3'd0, 4'd0);
    push_event(ACT_ALLOC_START, 64'd100, 5'd0);
    push_event(ACT_ALLOC_END, 64'd200, 5'd3);
    push_read(1'b0, 3'd0, 4'd3);
    drain();

    // Enable with the default bounds
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      next_bound[lv] = THRESH_RESET[lv];
    configure(32'd1);
    @(posedge clk);
    // End with nothing open (start was ignored while off)
    push_event(ACT_ALLOC_END, 64'd300, 5'd0);
    push_event(ACT_ALLOC_START, 64'd1000, 5'd0);
    push_event(ACT_ALLOC_END, 64'd1500, 5'd3);
    // Order above the last slot clamps
    push_event(ACT_ALLOC_START, 64'd2000, 5'd0);
    push_event(ACT_ALLOC_END, 64'd2000 + 64'd6000000, 5'd31);
    // Fault and speculative share one start
    push_event(ACT_FAULT_START, 64'd5000, 5'd0);
    push_event(ACT_SPEC_END, 64'd5000 + 64'd999999, 5'd0);
    // Delay equal to the last bound is not recorded
    push_event(ACT_SPEC_START, 64'd10, 5'd0);
    push_event(ACT_FAULT_END, 64'd10 + 64'd1000000000, 5'd0);
    push_event(ACT_FAULT_END, 64'd20000, 5'd0);
    // Backward time drops the delay and clears the start
    push_event(ACT_ALLOC_START, 64'hFFFF_FFFF_FFFF_FF00, 5'd0);
    push_event(ACT_ALLOC_END, 64'd100, 5'd1);
    push_event(ACT_ALLOC_END, 64'd200, 5'd1);
    // Start at time zero reads as not open
    push_event(ACT_ALLOC_START, 64'd0, 5'd0);
    push_event(ACT_ALLOC_END, 64'd500, 5'd2);
    push_event(ACT_NONE, ~64'd0, 5'd31);
    push_event(ACT_ALLOC_START, 64'hFFFF_FFFF_0000_0000, 5'd0);
    push_event(ACT_ALLOC_END, ~64'd0, 5'd10);
    push_read(1'b0, 3'd0, 4'd3);
    push_read(1'b1, 3'd0, 4'd3);
    push_read(1'b0, 3'd2, 4'd10);
    push_read(1'b1, 3'd0, 4'd12);
    push_read(1'b1, 3'd7, 4'd0);
    push_read(1'b0, 3'd6, 4'd15);
    push_read(1'b1, 3'd0, 4'd11);
    drain();

    // Default bounds, no idling
    run_phase(32'd1, 0, 0, 120);

    // Small ascending bounds, sender mostly idle
    acc = 0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      acc += $urandom_range(1 << (3 * lv + 4), 1);
      next_bound[lv] = acc;
    end
    run_phase(32'd1, 81, 0, 180);

    // Extreme bounds, receiver mostly stalled
    next_bound[0] = 32'd0;
    for (int lv = 1; lv < NUM_LEVELS - 1; lv++)
      next_bound[lv] = lv * 32'h2000_0000 + $urandom_range(32'h1FFF_FFFF);
    next_bound[NUM_LEVELS-1] = 32'hFFFF_FFFF;
    run_phase($urandom | 32'd1, 0, 81, 180);

    // Accounting off with junk in the upper enable bits; open starts persist
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      next_bound[lv] = $urandom;
    run_phase($urandom & ~32'd1, 35, 35, 60);

    // Unordered random bounds, both sides idling
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      next_bound[lv] = $urandom;
    run_phase($urandom | 32'd1, 35, 35, 140);

    // Widest bounds, then read back the whole table
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      next_bound[lv] = 32'hFFFF_FFFF;
    run_phase(32'd1, 0, 0, 60);
    @(posedge clk);
    recv_stall_pct = 35;
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      for (int sl = 0; sl < NUM_SLOTS; sl++)
        for (int k = 0; k < 2; k++)
          push_read(1'(k), READ_LEVEL_W'(lv), READ_SLOT_W'(sl));
    drain();

    $display("Ran %0d event transactions and checked %0d read results across six bound",
             events_taken, reads_checked);
    $display("settings, accounting off and on, and idle, stall and full-rate traffic.");
    if (fail_count == 0 && expected_reads.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
